@@ sv/cnv3_pkg.sv @@
// Shared types, constants and helper functions of the 3x3 convolution core.
package cnv3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int QUEUE_DEPTH    = 4;
  localparam int ACC_W          = 28;
  localparam int KSUM_W         = 20;
  localparam int MAG_W          = 27;
  localparam int DIV_W          = 19;
  localparam int CFG_DATA_W     = 48;
  localparam int CFG_INDEX_W    = 3;
  localparam logic [7:0] SAT_MAX = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd4;

  typedef struct packed {
    logic [7:0] pix_alpha;
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        run_last;
  } out_pixel_t;

  typedef struct packed {
    in_pixel_t [8:0] taps;
    logic [7:0]      alpha;
    logic [11:0]     row;
    logic [9:0]      col;
    logic            last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [15:0] coef(input logic [47:0] kt, input logic [47:0] km,
                                              input logic [47:0] kb, input logic [3:0] k);
    logic signed [15:0] c;
    unique case (k)
      4'd0: c = kt[15:0];
      4'd1: c = kt[31:16];
      4'd2: c = kt[47:32];
      4'd3: c = km[15:0];
      4'd4: c = km[31:16];
      4'd5: c = km[47:32];
      4'd6: c = kb[15:0];
      4'd7: c = kb[31:16];
      4'd8: c = kb[47:32];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chan(input in_pixel_t p, input int ch);
    logic [7:0] v;
    unique case (ch)
      0: v = p.pix_red;
      1: v = p.pix_green;
      default: v = p.pix_blue;
    endcase
    return v;
  endfunction

endpackage

@@ sv/cnv3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cnv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/cnv3_fifo.sv @@
// Short job queue between the window front end and the arithmetic back end.
module cnv3_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cnv3_pkg::job_t    push_data,
  input  logic              pop,
  output cnv3_pkg::job_t    pop_data,
  output cnv3_pkg::q_status_t status
);

  localparam int PW = $clog2(cnv3_pkg::QUEUE_DEPTH);

  cnv3_pkg::job_t   entry_r [cnv3_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;

  assign status.full  = (count_r == (PW+1)'(cnv3_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !status.full) begin
        entry_r[wr_ptr_r] <= push_data;
        wr_ptr_r          <= wr_ptr_r + 1'b1;
      end
      if (pop && !status.empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push && !status.full) - (PW+1)'(pop && !status.empty);
    end
  end

endmodule

@@ sv/cnv3_front.sv @@
// Front end: pixel intake, line stores, 3x3 window and output job generation.
module cnv3_front #(
  parameter int MAX_WIDTH  = cnv3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cnv3_pkg::in_pixel_t            in_data,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] frame_h,
  input  logic                           pos_clear,
  output logic                           job_push,
  output cnv3_pkg::job_t                 job,
  input  cnv3_pkg::q_status_t            q_status
);

  localparam int COL_W = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int FW_W  = $clog2(MAX_WIDTH+1);
  localparam int FH_W  = $clog2(MAX_HEIGHT+1);
  localparam int IW    = (FW_W > FH_W ? FW_W : FH_W) + 2;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_EMIT} state_t;

  state_t              state_r;
  logic [ROW_W-1:0]    ar_r;
  logic [COL_W-1:0]    ac_r;
  cnv3_pkg::in_pixel_t pix_r;
  cnv3_pkg::in_pixel_t win_r [3][3];
  logic [1:0]          e_r;
  logic [1:0]          rv_r;
  logic [1:0]          cv_r;
  logic                last_col_r;
  logic                last_row_r;

  cnv3_pkg::in_pixel_t older_rd;
  cnv3_pkg::in_pixel_t newer_rd;
  logic                ram_we;
  logic                last_col;
  logic                last_row;
  logic                e_valid;
  logic                later;
  logic [ROW_W-1:0]    orow;
  logic [COL_W-1:0]    ocol;
  logic [1:0]          wy [3];
  logic [1:0]          wx [3];
  logic [1:0]          cy;
  logic [1:0]          cx;
  logic signed [IW-1:0] lim_h;
  logic signed [IW-1:0] lim_w;
  logic [2:0]          m;

  function automatic logic [1:0] wsel(input logic signed [IW-1:0] o, input logic [1:0] d,
                                      input logic signed [IW-1:0] lim,
                                      input logic signed [IW-1:0] a);
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] t;
    y = $signed(o + IW'(d) - IW'(1));
    if (y < 0) y = '0;
    if (y > lim) y = lim;
    t = $signed(y - a + IW'(2));
    if (t < 0) t = '0;
    if (t > $signed(IW'(2))) t = $signed(IW'(2));
    return t[1:0];
  endfunction

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign ram_we   = (state_r == S_LOAD);

  cnv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ac_r),
    .wr_data (newer_rd),
    .rd_addr (ac_r),
    .rd_data (older_rd)
  );

  cnv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ac_r),
    .wr_data (pix_r),
    .rd_addr (ac_r),
    .rd_data (newer_rd)
  );

  assign last_col = ((FW_W+1)'(ac_r) + (FW_W+1)'(1)) >= (FW_W+1)'(frame_w);
  assign last_row = ((FH_W+1)'(ar_r) + (FH_W+1)'(1)) >= (FH_W+1)'(frame_h);

  always_comb begin
    lim_h   = $signed(IW'(frame_h) - IW'(1));
    lim_w   = $signed(IW'(frame_w) - IW'(1));
    orow    = e_r[1] ? ar_r : ar_r - 1'b1;
    ocol    = e_r[0] ? ac_r : ac_r - 1'b1;
    e_valid = rv_r[e_r[1]] && cv_r[e_r[0]];
    later   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      m = 3'(i);
      if (m > {1'b0, e_r} && rv_r[m[1]] && cv_r[m[0]]) later = 1'b1;
    end
    for (int d = 0; d < 3; d++) begin
      wy[d] = wsel($signed(IW'(orow)), 2'(d), lim_h, $signed(IW'(ar_r)));
      wx[d] = wsel($signed(IW'(ocol)), 2'(d), lim_w, $signed(IW'(ac_r)));
    end
    cy = wy[1];
    cx = wx[1];
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        job.taps[dy*3+dx] = win_r[wy[dy]][wx[dx]];
      end
    end
    job.alpha = win_r[cy][cx].pix_alpha;
    job.row   = 12'(orow);
    job.col   = 10'(ocol);
    job.last  = !later;
    job_push  = (state_r == S_EMIT) && e_valid && !q_status.full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ar_r    <= '0;
      ac_r    <= '0;
      e_r     <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pos_clear) begin
            ar_r <= '0;
            ac_r <= '0;
          end else if (in_valid) begin
            pix_r   <= in_data;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int r = 0; r < 3; r++) begin
            win_r[r][0] <= win_r[r][1];
            win_r[r][1] <= win_r[r][2];
          end
          win_r[0][2] <= older_rd;
          win_r[1][2] <= newer_rd;
          win_r[2][2] <= pix_r;
          rv_r        <= {last_row, ar_r != '0};
          cv_r        <= {last_col, ac_r != '0};
          last_col_r  <= last_col;
          last_row_r  <= last_row;
          e_r         <= '0;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (!e_valid || !q_status.full) begin
            e_r <= e_r + 1'b1;
            if (e_r == 2'd3) begin
              state_r <= S_IDLE;
              if (last_col_r) begin
                ac_r <= '0;
                ar_r <= last_row_r ? '0 : ar_r + 1'b1;
              end else begin
                ac_r <= ac_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/cnv3_back.sv @@
// Back end: serial multiply-accumulate over the taps, serial division and saturation.
module cnv3_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [47:0]           kernel_top,
  input  logic [47:0]           kernel_middle,
  input  logic [47:0]           kernel_bottom,
  input  cnv3_pkg::job_t        job,
  input  cnv3_pkg::q_status_t   q_status,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cnv3_pkg::out_pixel_t  out_data
);

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_DONE} state_t;

  state_t                              state_r;
  cnv3_pkg::job_t                      job_r;
  logic [3:0]                          k_r;
  logic [4:0]                          cnt_r;
  logic signed [cnv3_pkg::ACC_W-1:0]   acc_r [3];
  logic signed [cnv3_pkg::KSUM_W-1:0]  ksum_r;
  logic [cnv3_pkg::MAG_W-1:0]          num_r [3];
  logic [cnv3_pkg::DIV_W-1:0]          rem_r [3];
  logic [cnv3_pkg::DIV_W-1:0]          d_r;
  logic                                out_valid_r;
  cnv3_pkg::out_pixel_t                out_data_r;

  logic signed [15:0]                  c;
  logic signed [24:0]                  prod [3];
  logic [cnv3_pkg::DIV_W:0]            rem_sh [3];
  logic [7:0]                          res [3];
  logic signed [cnv3_pkg::ACC_W-1:0]   acc_abs [3];
  logic signed [cnv3_pkg::KSUM_W-1:0]  ksum_abs;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign job_pop   = (state_r == B_IDLE) && !q_status.empty;

  always_comb begin
    c        = cnv3_pkg::coef(kernel_top, kernel_middle, kernel_bottom, k_r);
    ksum_abs = ksum_r[cnv3_pkg::KSUM_W-1] ? -ksum_r : ksum_r;
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]    = $signed({1'b0, cnv3_pkg::chan(job_r.taps[k_r], ch)}) * c;
      rem_sh[ch]  = {rem_r[ch], num_r[ch][cnv3_pkg::MAG_W-1]};
      acc_abs[ch] = acc_r[ch][cnv3_pkg::ACC_W-1] ? -acc_r[ch] : acc_r[ch];
      if (ksum_r == '0) begin
        if (acc_r[ch] < 0) res[ch] = '0;
        else if (acc_r[ch] > $signed(cnv3_pkg::ACC_W'(cnv3_pkg::SAT_MAX))) begin
          res[ch] = cnv3_pkg::SAT_MAX;
        end else res[ch] = acc_r[ch][7:0];
      end else if (acc_r[ch][cnv3_pkg::ACC_W-1] ^ ksum_r[cnv3_pkg::KSUM_W-1]) begin
        res[ch] = '0;
      end else if (num_r[ch] > cnv3_pkg::MAG_W'(cnv3_pkg::SAT_MAX)) begin
        res[ch] = cnv3_pkg::SAT_MAX;
      end else begin
        res[ch] = num_r[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_status.empty) begin
            job_r   <= job;
            k_r     <= '0;
            ksum_r  <= '0;
            for (int ch = 0; ch < 3; ch++) acc_r[ch] <= '0;
            state_r <= B_MAC;
          end
        end
        B_MAC: begin
          for (int ch = 0; ch < 3; ch++) begin
            acc_r[ch] <= acc_r[ch] + cnv3_pkg::ACC_W'(prod[ch]);
          end
          ksum_r <= ksum_r + cnv3_pkg::KSUM_W'(c);
          k_r    <= k_r + 1'b1;
          if (k_r == 4'd8) state_r <= B_PREP;
        end
        B_PREP: begin
          for (int ch = 0; ch < 3; ch++) begin
            num_r[ch] <= acc_abs[ch][cnv3_pkg::MAG_W-1:0];
            rem_r[ch] <= '0;
          end
          d_r     <= ksum_abs[cnv3_pkg::DIV_W-1:0];
          cnt_r   <= '0;
          state_r <= (ksum_r == '0) ? B_DONE : B_DIV;
        end
        B_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (rem_sh[ch] >= {1'b0, d_r}) begin
              rem_r[ch] <= cnv3_pkg::DIV_W'(rem_sh[ch] - {1'b0, d_r});
              num_r[ch] <= {num_r[ch][cnv3_pkg::MAG_W-2:0], 1'b1};
            end else begin
              rem_r[ch] <= rem_sh[ch][cnv3_pkg::DIV_W-1:0];
              num_r[ch] <= {num_r[ch][cnv3_pkg::MAG_W-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(cnv3_pkg::MAG_W - 1)) state_r <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.out_red   <= res[0];
            out_data_r.out_green <= res[1];
            out_data_r.out_blue  <= res[2];
            out_data_r.out_alpha <= job_r.alpha;
            out_data_r.out_row   <= job_r.row;
            out_data_r.out_col   <= job_r.col;
            out_data_r.run_last  <= job_r.last;
            state_r              <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

@@ sv/conv3x3_normalized_rgb_core.sv @@
// Top level of the 3x3 normalized RGB convolution core with its register file.
// An input pixel holds the front end through the accept with its line-store read, one
// window update and four emit slots, one per candidate position, plus any queue-full cycles.
// In the back end each result passes the 9-tap serial multiply-accumulate, a preparation
// step and the 27-step serial divider, which is skipped when the kernel sum is zero.
// Synchronous active-low reset clears control state and registers; line stores need no
// clearing, as a row is read only after it is written.
module conv3x3_normalized_rgb_core #(
  parameter int MAX_WIDTH  = cnv3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cnv3_pkg::in_pixel_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cnv3_pkg::out_pixel_t                out_data,
  input  logic                                cfg_we,
  input  logic [cnv3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cnv3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW_W = $clog2(MAX_WIDTH+1);
  localparam int FH_W = $clog2(MAX_HEIGHT+1);
  localparam int FW_RST = MAX_WIDTH < 1024 ? MAX_WIDTH : 1024;
  localparam int FH_RST = MAX_HEIGHT < 4096 ? MAX_HEIGHT : 4096;

  logic [47:0]     kernel_top_r;
  logic [47:0]     kernel_middle_r;
  logic [47:0]     kernel_bottom_r;
  logic [FW_W-1:0] frame_w_r;
  logic [FH_W-1:0] frame_h_r;
  logic            pos_clear;
  logic [10:0]     w_raw;
  logic [12:0]     h_raw;

  logic                job_push;
  logic                job_pop;
  cnv3_pkg::job_t      push_job;
  cnv3_pkg::job_t      pop_job;
  cnv3_pkg::q_status_t q_status;

  assign w_raw     = cfg_data[10:0];
  assign h_raw     = cfg_data[12:0];
  assign pos_clear = cfg_we && (cfg_index == cnv3_pkg::REG_FRAME_WIDTH ||
                                cfg_index == cnv3_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_top_r    <= '0;
      kernel_middle_r <= 48'h10000;
      kernel_bottom_r <= '0;
      frame_w_r       <= FW_W'(FW_RST);
      frame_h_r       <= FH_W'(FH_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cnv3_pkg::REG_KERNEL_TOP:    kernel_top_r    <= cfg_data;
        cnv3_pkg::REG_KERNEL_MIDDLE: kernel_middle_r <= cfg_data;
        cnv3_pkg::REG_KERNEL_BOTTOM: kernel_bottom_r <= cfg_data;
        cnv3_pkg::REG_FRAME_WIDTH: begin
          if (w_raw == '0) frame_w_r <= FW_W'(1);
          else if (32'(w_raw) > MAX_WIDTH) frame_w_r <= FW_W'(MAX_WIDTH);
          else frame_w_r <= FW_W'(w_raw);
        end
        cnv3_pkg::REG_FRAME_HEIGHT: begin
          if (h_raw == '0) frame_h_r <= FH_W'(1);
          else if (32'(h_raw) > MAX_HEIGHT) frame_h_r <= FH_W'(MAX_HEIGHT);
          else frame_h_r <= FH_W'(h_raw);
        end
        default: ;
      endcase
    end
  end

  cnv3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .frame_w   (frame_w_r),
    .frame_h   (frame_h_r),
    .pos_clear (pos_clear),
    .job_push  (job_push),
    .job       (push_job),
    .q_status  (q_status)
  );

  cnv3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .status    (q_status)
  );

  cnv3_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .kernel_top    (kernel_top_r),
    .kernel_middle (kernel_middle_r),
    .kernel_bottom (kernel_bottom_r),
    .job           (pop_job),
    .q_status      (q_status),
    .job_pop       (job_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

@@ sv/cnv3_checker.sv @@
// Port-level checker for the convolution core and its bind to the top level.
module cnv3_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input cnv3_pkg::out_pixel_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result request changed.");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A new pixel request was taken before the window update.");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result request shown right after reset.");

endmodule

bind conv3x3_normalized_rgb_core cnv3_checker u_cnv3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/conv3x3_checker.sv @@
// Checker for the 3x3 convolution core: predicts each output pixel and compares it.
module conv3x3_checker
  import cnv3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_pixel_t              in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_pixel_t             out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] row_older [MAX_WIDTH_DEF];
  logic [31:0] row_newer [MAX_WIDTH_DEF];
  logic [31:0] window [9];
  logic [47:0] kernel [3];
  int          frame_w, frame_h, cur_row, cur_col;
  out_pixel_t  expected_pixels [$];

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [7:0] normalize(longint acc, longint ksum);
    if (ksum != 0) acc = acc / ksum;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function automatic out_pixel_t predict_pixel(int orow, int ocol, int ar, int ac);
    out_pixel_t         p;
    longint             acc [3];
    longint             ksum;
    logic signed [15:0] c;
    logic [31:0]        px;
    int                 y, x, wy, wx;
    acc = '{0, 0, 0};
    ksum = 0;
    for (int dy = 0; dy < 3; dy++) begin
      y = clampi(orow + dy - 1, 0, frame_h - 1);
      wy = clampi(y - ar + 2, 0, 2);
      for (int dx = 0; dx < 3; dx++) begin
        x = clampi(ocol + dx - 1, 0, frame_w - 1);
        wx = clampi(x - ac + 2, 0, 2);
        px = window[wy*3 + wx];
        c = kernel[dy][16*dx +: 16];
        ksum += c;
        for (int ch = 0; ch < 3; ch++) acc[ch] += longint'(px[8*ch +: 8]) * c;
      end
    end
    p.out_red   = normalize(acc[0], ksum);
    p.out_green = normalize(acc[1], ksum);
    p.out_blue  = normalize(acc[2], ksum);
    px = window[clampi(orow - ar + 2, 0, 2)*3 + clampi(ocol - ac + 2, 0, 2)];
    p.out_alpha = px[31:24];
    p.out_row   = orow[11:0];
    p.out_col   = ocol[9:0];
    p.run_last  = 1'b0;
    return p;
  endfunction

  task automatic accept_pixel(logic [31:0] pix);
    int         rows [2];
    int         cols [2];
    int         nr, nc;
    out_pixel_t p;
    nr = 0;
    nc = 0;
    for (int r = 0; r < 3; r++) begin
      window[r*3]     = window[r*3 + 1];
      window[r*3 + 1] = window[r*3 + 2];
    end
    window[2] = row_older[cur_col];
    window[5] = row_newer[cur_col];
    window[8] = pix;
    row_older[cur_col] = row_newer[cur_col];
    row_newer[cur_col] = pix;
    if (cur_row >= 1) begin
      rows[nr] = cur_row - 1;
      nr++;
    end
    if (cur_row + 1 >= frame_h) begin
      rows[nr] = cur_row;
      nr++;
    end
    if (cur_col >= 1) begin
      cols[nc] = cur_col - 1;
      nc++;
    end
    if (cur_col + 1 >= frame_w) begin
      cols[nc] = cur_col;
      nc++;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        p = predict_pixel(rows[i], cols[j], cur_row, cur_col);
        p.run_last = (i == nr - 1) && (j == nc - 1);
        expected_pixels.push_back(p);
      end
    end
    if (cur_col + 1 >= frame_w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= frame_h) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    int v;
    case (idx)
      REG_KERNEL_TOP:    kernel[0] = d;
      REG_KERNEL_MIDDLE: kernel[1] = d;
      REG_KERNEL_BOTTOM: kernel[2] = d;
      REG_FRAME_WIDTH: begin
        v = d[10:0];
        frame_w = clampi(v, 1, MAX_WIDTH_DEF);
        cur_row = 0;
        cur_col = 0;
      end
      REG_FRAME_HEIGHT: begin
        v = d[12:0];
        frame_h = clampi(v, 1, MAX_HEIGHT_DEF);
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_pixel_t e;
    if (!rst_n) begin
      kernel = '{48'h0, 48'h10000, 48'h0};
      frame_w = MAX_WIDTH_DEF;
      frame_h = MAX_HEIGHT_DEF;
      cur_row = 0;
      cur_col = 0;
      for (int i = 0; i < 9; i++) window[i] = '0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) accept_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("Unexpected output pixel %h", out_data);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10)
              $display("Mismatch: expected %h (r%0d c%0d rgba %h %h %h %h), got %h",
                       e, e.out_row, e.out_col, e.out_red, e.out_green, e.out_blue,
                       e.out_alpha, out_data);
            fail_count++;
          end
        end
      end
    end
    pending = expected_pixels.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

@@ verif/tb_conv3x3_normalized_rgb_core.sv @@
// Testbench top for the 3x3 convolution core: stimulus, register setup and verdict.
module tb_conv3x3_normalized_rgb_core;
  import cnv3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 6000;

  logic                   clk, rst_n;
  logic                   in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_pixel_t              in_data;
  out_pixel_t             out_data;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count, pending, pixels_sent, quiet_cycles;
  bit                     calm;

  conv3x3_normalized_rgb_core uut (.*);

  conv3x3_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("conv3x3_normalized_rgb_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 27);
  end

  task automatic send_pixel(logic [31:0] pix);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pix;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic setup(logic [47:0] kt, logic [47:0] km, logic [47:0] kb,
                       logic [10:0] w, logic [12:0] h);
    drain();
    write_reg(REG_KERNEL_TOP, kt);
    write_reg(REG_KERNEL_MIDDLE, km);
    write_reg(REG_KERNEL_BOTTOM, kb);
    write_reg(REG_FRAME_WIDTH, 48'(w));
    write_reg(REG_FRAME_HEIGHT, 48'(h));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_coef();
    logic [15:0] c;
    if ($urandom_range(7) == 0) c = 16'($urandom);
    else c = 16'($signed($urandom_range(16)) - 8);
    return c;
  endfunction

  function automatic logic [47:0] random_row();
    return {random_coef(), random_coef(), random_coef()};
  endfunction

  initial begin
    int w, h, n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixels_sent = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    setup(48'h0, 48'h10000, 48'h0, 11'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
    setup({3{16'h0001}}, {3{16'h0001}}, {3{16'h0001}}, 11'd0, 13'd0);
    send_pixel(32'h80FF_0102);
    send_pixel(32'h7F00_FEFD);
    setup({3{16'hFFFF}}, {16'hFFFF, 16'h0008, 16'hFFFF}, {3{16'hFFFF}}, 11'h7FF, 13'd1);
    for (int i = 0; i < 6; i++) send_pixel($urandom);
    setup({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'hFFFE, 16'h7FFF},
          {16'h0003, 16'h8000, 16'h0000}, 11'd1, 13'h1FFF);
    for (int i = 0; i < 5; i++) send_pixel($urandom);

    while (pixels_sent < 350) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      setup(random_row(), random_row(), random_row(), 11'(w), 13'(h));
      n = ($urandom_range(5) == 0) ? $urandom_range(1, w*h) : w*h * $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        calm = (pixels_sent >= 200 && pixels_sent < 270);
        if (pixels_sent == 150) drain();
        send_pixel($urandom);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("conv3x3_normalized_rgb_core test passed");
    end else begin
      $display("conv3x3_normalized_rgb_core test failed");
    end
    $finish;
  end
endmodule
